### hw/rtl/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
// No dependencies; used by wpm_front, wpm_back and the top level.
`timescale 1ns / 1ps

package wpm_pkg;

    localparam int PATTERN_MAX_DEF = 32;

    localparam logic [7:0] CH_ANY_ONE = 8'h3F;   // '?'
    localparam logic [7:0] CH_ANY_RUN = 8'h2A;   // '*'

    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        OP_APPEND = 2'd0,
        OP_TEXT   = 2'd1,
        OP_END    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CHAR_W-1:0] ch;
        logic             is_star;
        logic             is_any;
    } t_item;

endpackage

### hw/rtl/wildcard_pattern_matcher.sv
// Wildcard pattern matcher, top level. Instantiates wpm_front and wpm_back;
// depends on wpm_pkg.
`timescale 1ns / 1ps

// Load a pattern with tuser=0 (one byte per transfer; '?' matches any one
// byte, '*' any run including none), stream text with tuser=1, then send
// tuser=2 to get one result: tdata[0] matched, tdata[1] sticky overflow flag
// (set when an append found the store full; matching then uses the stored
// prefix). tuser=3 clears the pattern and the flag. Appends and clears also
// discard partial text. The block takes one transfer per cycle unless the
// two-entry input queue is full; the back end holds an end-of-text item while
// an earlier result waits on tready. One text byte updates all PATTERN_MAX+1
// prefix bits together through a ripple over the star positions. A result
// passes through the input queue and then the output register.
module wildcard_pattern_matcher #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [wpm_pkg::CHAR_W-1:0] i_s_axis_tdata,   // [7:0] character
    input  logic [wpm_pkg::FUNC_W-1:0] i_s_axis_tuser,   // [1:0] func
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [7:0]                 o_m_axis_tdata    // [0] matched, [1] pattern_overflow
);
    import wpm_pkg::*;

    t_item w_item;
    logic  w_item_valid;
    logic  w_item_ready;

    wpm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_item_valid    (w_item_valid),
        .i_item_ready    (w_item_ready),
        .o_item          (w_item)
    );

    wpm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (w_item_valid),
        .o_item_ready    (w_item_ready),
        .i_item          (w_item),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

### hw/rtl/wpm_front.sv
// Front end of the wildcard pattern matcher: input transfer, decode and a
// two-entry queue toward the back end. Depends on wpm_pkg.
`timescale 1ns / 1ps

module wpm_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [wpm_pkg::CHAR_W-1:0] i_s_axis_tdata,
    input  logic [wpm_pkg::FUNC_W-1:0] i_s_axis_tuser,
    output logic                       o_item_valid,
    input  logic                       i_item_ready,
    output wpm_pkg::t_item             o_item
);
    import wpm_pkg::*;

    t_item      r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_item      w_dec;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_dec.ch      = i_s_axis_tdata;
        w_dec.is_star = (i_s_axis_tdata == CH_ANY_RUN);
        w_dec.is_any  = (i_s_axis_tdata == CH_ANY_ONE);
        w_dec.op      = t_op'(i_s_axis_tuser);
    end

    assign o_s_axis_tready = (r_count != 2'd2);
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_item_valid    = (r_count != 2'd0);
    assign w_pop           = o_item_valid && i_item_ready;
    assign o_item          = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_dec;
        end
    end

endmodule

### hw/rtl/wpm_back.sv
// Back end of the wildcard pattern matcher: pattern store, prefix match
// vector update and the result register. Depends on wpm_pkg.
`timescale 1ns / 1ps

module wpm_back #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    output logic           o_item_ready,
    input  wpm_pkg::t_item i_item,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [7:0]     o_m_axis_tdata
);
    import wpm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [CHAR_W-1:0]    r_store [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_star;
    logic [PATTERN_MAX-1:0] r_any;
    logic [LEN_W-1:0]     r_len;
    logic                 r_ovf;
    logic                 r_arm;
    logic [PATTERN_MAX:0] r_lead;    // empty-text column: bit 0 plus leading stars
    logic [PATTERN_MAX:0] r_bits;
    logic                 r_out_valid;
    logic [1:0]           r_out_data;

    logic [PATTERN_MAX:0] w_eff;
    logic [PATTERN_MAX:0] n_bits;
    logic                 w_fire;
    logic                 w_room;

    assign w_eff  = r_arm ? r_lead : r_bits;
    assign w_room = (r_len < LEN_W'(PATTERN_MAX));

    // One text byte: every prefix bit at once, stars ripple upward.
    always_comb begin
        n_bits[0] = 1'b0;
        for (int i = 1; i <= PATTERN_MAX; i++) begin
            if (LEN_W'(i) <= r_len) begin
                if (r_star[i-1]) begin
                    n_bits[i] = n_bits[i-1] | w_eff[i];
                end else begin
                    n_bits[i] = w_eff[i-1] & (r_any[i-1] | (r_store[i-1] == i_item.ch));
                end
            end else begin
                n_bits[i] = 1'b0;
            end
        end
    end

    assign o_item_ready    = (i_item.op != OP_END) || !r_out_valid || i_m_axis_tready;
    assign w_fire          = i_item_valid && o_item_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_arm       <= 1'b1;
            r_lead      <= {{PATTERN_MAX{1'b0}}, 1'b1};
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                case (i_item.op)
                    OP_APPEND: begin
                        r_arm <= 1'b1;
                        if (w_room) begin
                            r_len <= r_len + 1'b1;
                            for (int i = 0; i < PATTERN_MAX; i++) begin
                                if (LEN_W'(i) == r_len) begin
                                    r_lead[i+1] <= r_lead[i] & i_item.is_star;
                                end
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    OP_TEXT: begin
                        r_arm <= 1'b0;
                    end
                    OP_END: begin
                        r_arm       <= 1'b1;
                        r_out_valid <= 1'b1;
                    end
                    default: begin
                        r_arm  <= 1'b1;
                        r_len  <= '0;
                        r_ovf  <= 1'b0;
                        r_lead <= {{PATTERN_MAX{1'b0}}, 1'b1};
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (i_item.op == OP_APPEND) begin
                for (int i = 0; i < PATTERN_MAX; i++) begin
                    if (LEN_W'(i) == r_len) begin
                        r_store[i] <= i_item.ch;
                        r_star[i]  <= i_item.is_star;
                        r_any[i]   <= i_item.is_any;
                    end
                end
            end
            if (i_item.op == OP_TEXT) begin
                r_bits <= n_bits;
            end
            if (i_item.op == OP_END) begin
                r_out_data <= {r_ovf, w_eff[r_len]};
            end
        end
    end

endmodule

### tb/tb_top.sv
// Self-checking testbench for wildcard_pattern_matcher: pattern/text/end/clear streams with
// random handshake gaps, checked against a bit-level prediction of the prefix-match bits.
// Depends on wpm_pkg and the wildcard_pattern_matcher RTL.
`timescale 1ns / 1ps

module tb_top;
    import wpm_pkg::*;

    localparam int PMAX = PATTERN_MAX_DEF;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_verdict;

    class match_scoreboard;
        logic [7:0]    pat [PMAX];
        int unsigned   plen;
        logic [PMAX:0] prefix_ok;
        logic          sticky_ovf;
        t_verdict      expected_verdicts[$];
        int unsigned   errors;
        int unsigned   verdicts_seen;
        int unsigned   matches_seen;
        int unsigned   overflows_seen;

        function new();
            plen = 0;
            sticky_ovf = 1'b0;
            errors = 0;
            verdicts_seen = 0;
            matches_seen = 0;
            overflows_seen = 0;
            rearm();
        endfunction

        // empty-text column: bit 0 plus the run of leading stars
        function void rearm();
            prefix_ok = '0;
            prefix_ok[0] = 1'b1;
            for (int i = 1; i <= plen; i++) begin
                prefix_ok[i] = (pat[i-1] == CH_ANY_RUN) && prefix_ok[i-1];
            end
        endfunction

        function void step_text(logic [7:0] c);
            logic [PMAX:0] prev;
            prev = prefix_ok;
            prefix_ok[0] = 1'b0;
            for (int i = 1; i <= plen; i++) begin
                if (pat[i-1] == CH_ANY_RUN) begin
                    prefix_ok[i] = prefix_ok[i-1] || prev[i];
                end else begin
                    prefix_ok[i] = prev[i-1] && (pat[i-1] == CH_ANY_ONE || pat[i-1] == c);
                end
            end
        endfunction

        function void note_item(t_op op, logic [7:0] c);
            t_verdict v;
            case (op)
                OP_APPEND: begin
                    if (plen < PMAX) begin
                        pat[plen] = c;
                        plen++;
                    end else begin
                        sticky_ovf = 1'b1;
                    end
                    rearm();
                end
                OP_TEXT: step_text(c);
                OP_END: begin
                    v.matched = prefix_ok[plen];
                    v.overflow = sticky_ovf;
                    expected_verdicts.push_back(v);
                    rearm();
                end
                default: begin
                    plen = 0;
                    sticky_ovf = 1'b0;
                    rearm();
                end
            endcase
        endfunction

        function void check_verdict(logic [7:0] data);
            t_verdict want;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result, tdata=%h", $time, data);
                errors++;
                return;
            end
            want = expected_verdicts.pop_front();
            verdicts_seen++;
            if (data[0]) matches_seen++;
            if (data[1]) overflows_seen++;
            if (data[0] !== want.matched) begin
                $display("%0t: matched mismatch: expected %0b, actual %0b",
                         $time, want.matched, data[0]);
                errors++;
            end
            if (data[1] !== want.overflow) begin
                $display("%0t: pattern_overflow mismatch: expected %0b, actual %0b",
                         $time, want.overflow, data[1]);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata = '0;
    logic [1:0] i_s_axis_tuser = '0;
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;

    bit              quiet_stretch = 1'b0;
    int unsigned     items_sent = 0;
    match_scoreboard board;

    wildcard_pattern_matcher uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] character
        .i_s_axis_tuser  (i_s_axis_tuser),   // [1:0] func
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)    // [0] matched, [1] pattern_overflow
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= quiet_stretch || ($urandom_range(0, 99) >= 38);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_verdict(o_m_axis_tdata);
        end
    end

    task automatic send(t_op op, logic [7:0] c);
        @(negedge i_clk);
        while (!quiet_stretch && $urandom_range(0, 99) < 38) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= c;
        i_s_axis_tuser <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_item(op, c);
        items_sent++;
    endtask

    function automatic logic [7:0] pattern_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return "a";
        if (r < 50) return "b";
        if (r < 65) return CH_ANY_ONE;
        if (r < 85) return CH_ANY_RUN;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] text_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return "a";
        if (r < 70) return "b";
        if (r < 76) return CH_ANY_ONE;
        if (r < 82) return CH_ANY_RUN;
        return 8'($urandom);
    endfunction

    initial begin
        logic [7:0]  txt[$];
        int unsigned n;
        int unsigned kind;
        bit          first_long;

        board = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern vs empty and non-empty text
        send(OP_END, 8'h00);
        send(OP_TEXT, 8'h00);
        send(OP_END, 8'hFF);
        // star-only pattern, empty text
        send(OP_APPEND, CH_ANY_RUN);
        send(OP_END, 8'h00);
        send(OP_APPEND, 8'hFF);
        send(OP_TEXT, "z");
        send(OP_TEXT, 8'hFF);
        send(OP_END, 8'h5A);
        send(OP_CLEAR, 8'hA5);
        // literal wildcards as text bytes
        send(OP_APPEND, CH_ANY_ONE);
        send(OP_APPEND, "c");
        send(OP_TEXT, CH_ANY_RUN);
        send(OP_TEXT, "c");
        send(OP_END, 8'h00);
        // pattern edited in the middle of a text
        send(OP_TEXT, "x");
        send(OP_APPEND, CH_ANY_RUN);
        send(OP_TEXT, "q");
        send(OP_TEXT, "c");
        send(OP_END, 8'h00);
        send(OP_TEXT, "c");
        send(OP_END, 8'h00);
        send(OP_CLEAR, 8'h00);
        send(OP_TEXT, CH_ANY_RUN);
        send(OP_END, 8'h00);

        first_long = 1'b1;
        while (items_sent < 1725) begin
            quiet_stretch = (items_sent >= 700 && items_sent < 1000);
            if ($urandom_range(0, 4) != 0) send(OP_CLEAR, 8'($urandom));
            // mostly short patterns; a few overflow the store
            n = (first_long || $urandom_range(0, 99) < 6) ? $urandom_range(30, 40)
                                                          : $urandom_range(0, 8);
            first_long = 1'b0;
            repeat (n) send(OP_APPEND, pattern_byte());
            repeat ($urandom_range(1, 4)) begin
                txt.delete();
                kind = $urandom_range(0, 9);
                if (kind < 6) begin
                    for (int i = 0; i < board.plen; i++) begin
                        if (board.pat[i] == CH_ANY_RUN) begin
                            repeat ($urandom_range(0, 3)) txt.push_back(text_byte());
                        end else if (board.pat[i] == CH_ANY_ONE) begin
                            txt.push_back(text_byte());
                        end else begin
                            txt.push_back(board.pat[i]);
                        end
                    end
                    if (kind == 5 && txt.size() > 0) txt[$urandom_range(0, txt.size() - 1)] = text_byte();
                    if (kind == 4 && txt.size() > 0) void'(txt.pop_back());
                end else begin
                    repeat ($urandom_range(0, 10)) txt.push_back(text_byte());
                end
                foreach (txt[i]) begin
                    if ($urandom_range(0, 99) < 3) send(t_op'($urandom_range(0, 3)), 8'($urandom));
                    send(OP_TEXT, txt[i]);
                end
                send(OP_END, 8'($urandom));
            end
        end
        quiet_stretch = 1'b0;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        n = 0;
        while (board.expected_verdicts.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (20) @(posedge i_clk);
        if (board.expected_verdicts.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     board.expected_verdicts.size());
        end
        $display("Sent %0d transfers; checked %0d end-of-text results (%0d matches, %0d overflow)",
                 items_sent, board.verdicts_seen, board.matches_seen, board.overflows_seen);
        if (board.errors == 0 && board.expected_verdicts.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
